// ----- rtl/ecl_pkg.sv -----
// ----------------------------------------------------------------------------
// ecl_pkg
// Shared constants, codes and recipe lookup functions for the error code
// LED blinker.
// ----------------------------------------------------------------------------
package ecl_pkg;

   localparam int MAX_STEPS = 20;
   localparam int PHASE_W   = $clog2(MAX_STEPS + 1);
   localparam int DUR_W     = 13;
   localparam int LEVEL_W   = 15;
   localparam int ELAPSED_W = 8;
   localparam int KEY_W     = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_ADR_W = CSR_IDX_W + 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [DUR_W-1:0] SINCE_MAX = '1;

   typedef logic [PHASE_W-1:0] phase_type;
   typedef logic [DUR_W-1:0]   dur_type;
   typedef logic [LEVEL_W-1:0] level_type;

   // status classes
   localparam logic [1:0] CLS_NUMERIC = 2'd0;
   localparam logic [1:0] CLS_PROG    = 2'd1;
   localparam logic [1:0] CLS_CONFIG  = 2'd2;
   localparam logic [1:0] CLS_MATCH   = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LED_INVERTED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NORMAL_LEVEL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ATTENTION_LEVEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_LEVEL       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEADY_LEVEL    = 3'd4;

   // phase durations in ms
   localparam dur_type DUR_HEART_ON  = 13'd100;
   localparam dur_type DUR_HEART_OFF = 13'd3000;
   localparam dur_type DUR_PROG      = 13'd200;
   localparam dur_type DUR_CFG_ON    = 13'd3000;
   localparam dur_type DUR_CFG_OFF   = 13'd0;
   localparam dur_type DUR_MATCH_ON  = 13'd1000;
   localparam dur_type DUR_MATCH_OFF = 13'd200;
   localparam dur_type DUR_SHORT_ON  = 13'd200;
   localparam dur_type DUR_SHORT_OFF = 13'd300;
   localparam dur_type DUR_LONG_ON   = 13'd1200;
   localparam dur_type DUR_LONG_OFF  = 13'd400;
   localparam dur_type DUR_GROUP_GAP = 13'd600;
   localparam dur_type DUR_FRAME_GAP = 13'd5000;

   localparam logic [3:0] ERR_GROUP_MAX = 4'd5;
   localparam logic [3:0] ERR_MAX       = 4'd10;
   localparam phase_type  LEN_PAIR      = 5'd2;
   localparam phase_type  LEN_CODE      = 5'd10;
   localparam phase_type  LAST_CODE_IDX = LEN_CODE - 5'd1;

   function automatic phase_type recipe_len(input logic [1:0] cls, input logic [3:0] err);
      phase_type len;
      if (cls != CLS_NUMERIC || err == 4'd0) begin
         len = LEN_PAIR;
      end else if (err <= ERR_MAX) begin
         len = LEN_CODE;
      end else begin
         len = '0;
      end
      return len;
   endfunction

   function automatic dur_type recipe_dur(input logic [1:0] cls, input logic [3:0] err,
                                          input phase_type idx);
      dur_type    d;
      logic [3:0] pair;
      logic       odd;
      logic [3:0] k;
      pair = idx[PHASE_W-1:1];
      odd  = idx[0];
      k    = err - ERR_GROUP_MAX;
      d    = '0;
      case (cls)
         CLS_PROG:   d = DUR_PROG;
         CLS_CONFIG: d = odd ? DUR_CFG_OFF : DUR_CFG_ON;
         CLS_MATCH:  d = odd ? DUR_MATCH_OFF : DUR_MATCH_ON;
         default: begin
            if (err == 4'd0) begin
               d = odd ? DUR_HEART_OFF : DUR_HEART_ON;
            end else if (idx == LAST_CODE_IDX && err <= ERR_MAX) begin
               d = DUR_FRAME_GAP;
            end else if (err <= ERR_GROUP_MAX) begin
               if (pair < err) begin
                  if (odd) begin
                     d = ((pair + 4'd1) == err) ? DUR_GROUP_GAP : DUR_SHORT_OFF;
                  end else begin
                     d = DUR_SHORT_ON;
                  end
               end else begin
                  d = odd ? DUR_LONG_OFF : DUR_LONG_ON;
               end
            end else if (err <= ERR_MAX) begin
               if (pair < k) begin
                  d = odd ? DUR_LONG_OFF : DUR_LONG_ON;
               end else begin
                  d = odd ? DUR_SHORT_OFF : DUR_SHORT_ON;
               end
            end else begin
               d = '0;
            end
         end
      endcase
      return d;
   endfunction

endpackage

// ----- rtl/error_code_led_blinker.sv -----
// ----------------------------------------------------------------------------
// error_code_led_blinker
// Drives an LED through blink recipes chosen by the reported status.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item per time sample, carrying the ms elapsed since the
//   previous item and the current status. rsp channel: one item per req
//   item, with the logical LED phase and the level for the pin.
//   Registers sit on an APB-style port at byte address 4*i; pready is tied
//   high and writes land in the access cycle.
//   Path: an item passes through the input register, then the result
//   register. Throughput: one item per cycle while rsp_stall is low; the
//   work for an item (an add, a saturate, a recipe lookup, a compare, the
//   phase step and the level select) sits between the two registers.
//   Reset: the blink state is cleared, the elapsed counter is saturated and
//   the first item always starts a fresh recipe; registers take their
//   reset values.
//   Stall: a stalled result holds in the result register; the input
//   register then fills and req_stall rises, so nothing is lost.
// ----------------------------------------------------------------------------
module error_code_led_blinker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ecl_pkg::ELAPSED_W-1:0]    req_elapsed_ms,
   input  logic [1:0]                       req_status_class,
   input  logic [3:0]                       req_error_number,
   input  logic                             req_not_connected,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_led_on,
   output logic [ecl_pkg::LEVEL_W-1:0]      rsp_pin_value,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ecl_pkg::CSR_ADR_W-1:0]    paddr,
   input  logic [ecl_pkg::CSR_DAT_W-1:0]    pwdata,
   output logic [ecl_pkg::CSR_DAT_W-1:0]    prdata,
   output logic                             pready
);
   import ecl_pkg::*;

   // configuration registers
   logic      led_inverted_ff;
   level_type normal_level_ff, attention_level_ff, off_level_ff, steady_level_ff;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [ELAPSED_W-1:0] s1_elapsed_ff;
   logic [1:0]           s1_class_ff;
   logic [3:0]           s1_err_ff;
   logic                 s1_nc_ff;

   // blink state
   logic              st_valid_ff;
   logic [KEY_W-1:0]  last_status_ff;
   phase_type         phase_ff, phase_in;
   dur_type           since_ff, since_in;
   logic              lit_ff, lit_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_led_ff;
   level_type rsp_pin_ff, pin_in;

   logic              adv, take_in;
   logic [KEY_W-1:0]  key;
   logic              change;
   phase_type         phase0, phase_nx, len;
   logic              lit0;
   logic [DUR_W:0]    sum;
   dur_type           since_sat, dur;
   logic              toggle, running, normal;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADR_W-1:2];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_comb begin
      prdata = '0;
      case (csr_idx)
         REG_LED_INVERTED:    prdata = {{(CSR_DAT_W-1){1'b0}}, led_inverted_ff};
         REG_NORMAL_LEVEL:    prdata = {{(CSR_DAT_W-LEVEL_W){1'b0}}, normal_level_ff};
         REG_ATTENTION_LEVEL: prdata = {{(CSR_DAT_W-LEVEL_W){1'b0}}, attention_level_ff};
         REG_OFF_LEVEL:       prdata = {{(CSR_DAT_W-LEVEL_W){1'b0}}, off_level_ff};
         REG_STEADY_LEVEL:    prdata = {{(CSR_DAT_W-LEVEL_W){1'b0}}, steady_level_ff};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_inverted_ff    <= 1'b0;
         normal_level_ff    <= 15'd1;
         attention_level_ff <= 15'd1;
         off_level_ff       <= 15'd0;
         steady_level_ff    <= 15'd0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_LED_INVERTED:    led_inverted_ff    <= pwdata[0];
            REG_NORMAL_LEVEL:    normal_level_ff    <= pwdata[LEVEL_W-1:0];
            REG_ATTENTION_LEVEL: attention_level_ff <= pwdata[LEVEL_W-1:0];
            REG_OFF_LEVEL:       off_level_ff       <= pwdata[LEVEL_W-1:0];
            REG_STEADY_LEVEL:    steady_level_ff    <= pwdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign adv       = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~adv;
   assign take_in   = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (adv) s1_valid_in = 1'b0;
      if (take_in) s1_valid_in = 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff & ~rsp_stall) rsp_valid_in = 1'b0;
      if (adv) rsp_valid_in = 1'b1;
   end

   // blink step
   always_comb begin
      key       = {s1_nc_ff, s1_err_ff, s1_class_ff};
      change    = ~st_valid_ff | (key != last_status_ff);
      phase0    = change ? '0 : phase_ff;
      lit0      = change ? ~led_inverted_ff : lit_ff;
      len       = recipe_len(s1_class_ff, s1_err_ff);
      sum       = {1'b0, since_ff} + {{(DUR_W+1-ELAPSED_W){1'b0}}, s1_elapsed_ff};
      since_sat = sum[DUR_W] ? SINCE_MAX : sum[DUR_W-1:0];
      dur       = recipe_dur(s1_class_ff, s1_err_ff, phase0);
      toggle    = since_sat >= dur;
      phase_nx  = phase0 + 5'd1;
      if (phase_nx >= len) phase_nx = '0;
      phase_in  = toggle ? phase_nx : phase0;
      since_in  = toggle ? '0 : since_sat;
      lit_in    = toggle ? ~lit0 : lit0;
      running   = (s1_class_ff == CLS_NUMERIC) && (s1_err_ff == 4'd0);
      normal    = running || (s1_class_ff == CLS_CONFIG)
                  || ((s1_class_ff == CLS_NUMERIC) && s1_nc_ff);
      if (running && steady_level_ff != '0) begin
         pin_in = steady_level_ff;
      end else if (lit_in) begin
         pin_in = normal ? normal_level_ff : attention_level_ff;
      end else begin
         pin_in = off_level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_valid_ff  <= 1'b0;
         phase_ff     <= '0;
         since_ff     <= SINCE_MAX;
         lit_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            st_valid_ff <= 1'b1;
            phase_ff    <= phase_in;
            since_ff    <= since_in;
            lit_ff      <= lit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         s1_elapsed_ff <= req_elapsed_ms;
         s1_class_ff   <= req_status_class;
         s1_err_ff     <= req_error_number;
         s1_nc_ff      <= req_not_connected;
      end
      if (adv) begin
         last_status_ff <= key;
         rsp_led_ff     <= lit_in;
         rsp_pin_ff     <= pin_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_on    = rsp_led_ff;
   assign rsp_pin_value = rsp_pin_ff;

`ifndef SYNTH
   a_phase_in_recipe: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= LAST_CODE_IDX)
      else $error("phase index beyond longest recipe");

   a_restart_phase: assert property (@(posedge clock) disable iff (reset)
      (adv && change) |=> (phase_ff == 5'd0 || phase_ff == 5'd1))
      else $error("status change did not restart the recipe");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty input register");

   a_empty_recipe_phase: assert property (@(posedge clock) disable iff (reset)
      (st_valid_ff && last_status_ff[1:0] == CLS_NUMERIC
       && last_status_ff[5:2] > ERR_MAX) |-> phase_ff == 5'd0)
      else $error("empty recipe left phase nonzero");
`endif

endmodule
